[hw/rtl/es2cd_pkg.sv]
// es2cd_pkg: constants, microcode word format and control store for the
// epoch seconds to civil date converter; used by es2cd_seq and the core in hw/rtl
package es2cd_pkg;

  localparam int PC_W   = 4;
  localparam int K_W    = 4;
  localparam int QUO_W  = 16;
  localparam int DAYS_W = 16;

  // calendar constants
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic signed [17:0] ZONE_STEP = 18'sd3600;
  localparam logic [11:0] BASE_YEAR     = 12'd1970;
  // only century year in range that is not a leap year (2000 is one)
  localparam logic [11:0] NONLEAP_CENTURY = 12'd2100;
  localparam logic [8:0]  YEAR_LEN      = 9'd365;
  localparam logic [8:0]  LEAP_YEAR_LEN = 9'd366;
  localparam logic [4:0]  LEAP_FEB_LEN  = 5'd29;
  localparam logic [3:0]  FEB           = 4'd1;
  localparam logic [3:0]  LAST_MONTH    = 4'd11;

  // rounded-up reciprocals, exact over the operand ranges used:
  // day  : (count >> 7) * RECIP_DAY  >> 35, i.e. / 675 after / 128
  // hour : (rem >> 4)   * RECIP_HOUR >> 21, i.e. / 225 after / 16
  // min  : (rem >> 2)   * RECIP_MIN  >> 14, i.e. / 15 after / 4
  localparam logic [25:0] RECIP_DAY  = 26'd50903317;
  localparam logic [25:0] RECIP_HOUR = 26'd9321;
  localparam logic [25:0] RECIP_MIN  = 26'd1093;

  // microcode operations
  localparam logic [3:0] OP_IDLE  = 4'd0;
  localparam logic [3:0] OP_ADJ   = 4'd1;
  localparam logic [3:0] OP_DIV   = 4'd2;
  localparam logic [3:0] OP_MOV   = 4'd3;
  localparam logic [3:0] OP_YEAR  = 4'd4;
  localparam logic [3:0] OP_MONTH = 4'd5;
  localparam logic [3:0] OP_DONE  = 4'd6;

  // divisor / destination select
  localparam logic [1:0] SEL_DAY  = 2'd0;
  localparam logic [1:0] SEL_HOUR = 2'd1;
  localparam logic [1:0] SEL_MIN  = 2'd2;

  typedef struct packed {
    logic [3:0]      op;
    logic [1:0]      dsel;
    logic [K_W-1:0]  iters;
    logic            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic [3:0]     op;
    logic [1:0]     dsel;
    logic [K_W-1:0] k;
  } seq_ctrl_t;

  // control store: a step advances (or jumps) when its go condition holds,
  // otherwise it repeats with the iteration counter counting down
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    w = '{op: OP_IDLE, dsel: SEL_DAY, iters: 4'd0, jmp: 1'b0, target: 4'd0};
    case (addr)
      4'd0:  w = '{op: OP_IDLE,  dsel: SEL_DAY,  iters: 4'd0,  jmp: 1'b0, target: 4'd0};
      4'd1:  w = '{op: OP_ADJ,   dsel: SEL_DAY,  iters: 4'd0,  jmp: 1'b0, target: 4'd0};
      4'd2:  w = '{op: OP_DIV,   dsel: SEL_DAY,  iters: 4'd0,  jmp: 1'b0, target: 4'd0};
      4'd3:  w = '{op: OP_MOV,   dsel: SEL_DAY,  iters: 4'd0,  jmp: 1'b0, target: 4'd0};
      4'd4:  w = '{op: OP_DIV,   dsel: SEL_HOUR, iters: 4'd0,  jmp: 1'b0, target: 4'd0};
      4'd5:  w = '{op: OP_MOV,   dsel: SEL_HOUR, iters: 4'd0,  jmp: 1'b0, target: 4'd0};
      4'd6:  w = '{op: OP_DIV,   dsel: SEL_MIN,  iters: 4'd0,  jmp: 1'b0, target: 4'd0};
      4'd7:  w = '{op: OP_MOV,   dsel: SEL_MIN,  iters: 4'd0,  jmp: 1'b0, target: 4'd0};
      4'd8:  w = '{op: OP_YEAR,  dsel: SEL_DAY,  iters: 4'd0,  jmp: 1'b0, target: 4'd0};
      4'd9:  w = '{op: OP_MONTH, dsel: SEL_DAY,  iters: 4'd0,  jmp: 1'b0, target: 4'd0};
      4'd10: w = '{op: OP_DONE,  dsel: SEL_DAY,  iters: 4'd0,  jmp: 1'b1, target: 4'd0};
      default: w = '{op: OP_IDLE, dsel: SEL_DAY, iters: 4'd0, jmp: 1'b1, target: 4'd0};
    endcase
    return w;
  endfunction

  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != NONLEAP_CENTURY);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      4'd1:                                      len = leap ? LEAP_FEB_LEN : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[hw/rtl/es2cd_if.sv]
// es2cd_if: valid/ready channel interfaces for the request (epoch seconds)
// and the response (civil date and time); no dependencies
interface es2cd_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport src (output valid, output epoch_seconds, input ready);
  modport snk (input valid, input epoch_seconds, output ready);
endinterface

interface es2cd_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport src (output valid, output year, output month, output day_of_month,
               output hour, output minute, output second, input ready);
  modport snk (input valid, input year, input month, input day_of_month,
               input hour, input minute, input second, output ready);
endinterface

[hw/rtl/es2cd_seq.sv]
// es2cd_seq: microcode sequencer, step counter plus iteration counter
// depends on es2cd_pkg (control store and word formats)
module es2cd_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  output es2cd_pkg::seq_ctrl_t  ctrl
);

  logic [es2cd_pkg::PC_W-1:0] pc;
  logic [es2cd_pkg::PC_W-1:0] pc_next;
  logic [es2cd_pkg::K_W-1:0]  k;
  logic [es2cd_pkg::K_W-1:0]  k_next;
  es2cd_pkg::ucode_t          word;
  es2cd_pkg::ucode_t          nword;

  always_comb begin
    word    = es2cd_pkg::ucode_rom(pc);
    pc_next = pc;
    if (go) begin
      pc_next = word.jmp ? word.target : pc + 4'd1;
    end
    nword = es2cd_pkg::ucode_rom(pc_next);
    // iteration count loads on entry to a step, counts down while it repeats
    k_next = go ? nword.iters : k - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      k  <= '0;
    end else begin
      pc <= pc_next;
      k  <= k_next;
    end
  end

  assign ctrl.op   = word.op;
  assign ctrl.dsel = word.dsel;
  assign ctrl.k    = k;

endmodule

[hw/rtl/epoch_seconds_to_civil_date_core.sv]
// epoch_seconds_to_civil_date_core: after the request transfer, the sequencer runs
// adjust, then divide and move for days, hours and minutes, then the year walk and
// the month walk, and the done step loads the response; a response still held
// stalls the done step. One request at a time: the next is taken in the idle step
// after the result is loaded into the output register.
// rst (synchronous) clears the zone offset to 0, the sequencer and response valid
module epoch_seconds_to_civil_date_core (
  input  logic               clk,
  input  logic               rst,
  es2cd_req_if.snk           req,
  es2cd_rsp_if.src           rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration register
  logic signed [4:0] zone;

  // datapath registers
  logic [31:0]                  epoch;
  logic [31:0]                  rem;
  logic [es2cd_pkg::QUO_W-1:0]  quo;
  logic [es2cd_pkg::DAYS_W-1:0] days;
  logic [11:0]                  year;
  logic [3:0]                   month;
  logic [4:0]                   hour;
  logic [5:0]                   minute;
  logic [5:0]                   second;

  es2cd_pkg::seq_ctrl_t ctrl;
  logic                 go;

  // combinational helpers
  logic signed [17:0]          zone_ext;
  logic signed [17:0]          zone_secs;
  logic [33:0]                 adj;
  logic [31:0]                 adj_sat;
  logic [16:0]                 divisor;
  logic [24:0]                 mul_a;
  logic [25:0]                 mul_b;
  logic [50:0]                 prod;
  logic [es2cd_pkg::QUO_W-1:0] quo_calc;
  logic [32:0]                 back;
  logic [31:0]                 rem_low;
  logic                        leap;
  logic [8:0]                  ylen;
  logic [4:0]                  mlen;

  es2cd_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .ctrl (ctrl)
  );

  // apb register port, write decode on the word address
  assign pready = 1'b1;
  assign prdata = {27'd0, zone};

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      zone <= pwdata[4:0];
    end
  end

  // request channel is open only while the sequencer sits in its idle step
  assign req.ready = !rst && (ctrl.op == es2cd_pkg::OP_IDLE);

  always_comb begin
    // zone offset in seconds, then saturate the adjusted count to 32 bits
    zone_ext  = {{13{zone[4]}}, zone};
    zone_secs = zone_ext * es2cd_pkg::ZONE_STEP;
    adj       = {2'b00, epoch} + {{16{zone_secs[17]}}, zone_secs};
    if (adj[33]) begin
      adj_sat = '0;
    end else if (adj[32]) begin
      adj_sat = '1;
    end else begin
      adj_sat = adj[31:0];
    end

    // quotient by reciprocal multiplication, the low factor of the divisor
    // (a power of two) comes off as a shift first
    case (ctrl.dsel)
      es2cd_pkg::SEL_HOUR: begin
        divisor = es2cd_pkg::SECS_PER_HOUR;
        mul_a   = {12'd0, rem[16:4]};
        mul_b   = es2cd_pkg::RECIP_HOUR;
      end
      es2cd_pkg::SEL_MIN: begin
        divisor = es2cd_pkg::SECS_PER_MIN;
        mul_a   = {15'd0, rem[11:2]};
        mul_b   = es2cd_pkg::RECIP_MIN;
      end
      default: begin
        divisor = es2cd_pkg::SECS_PER_DAY;
        mul_a   = rem[31:7];
        mul_b   = es2cd_pkg::RECIP_DAY;
      end
    endcase
    prod = mul_a * mul_b;
    case (ctrl.dsel)
      es2cd_pkg::SEL_HOUR: quo_calc = prod[36:21];
      es2cd_pkg::SEL_MIN:  quo_calc = prod[29:14];
      default:             quo_calc = prod[50:35];
    endcase

    // remainder from the registered quotient
    back    = quo * divisor;
    rem_low = rem - back[31:0];

    // year and month lengths
    leap = es2cd_pkg::is_leap(year);
    ylen = leap ? es2cd_pkg::LEAP_YEAR_LEN : es2cd_pkg::YEAR_LEN;
    mlen = es2cd_pkg::month_len(month, leap);
  end

  // go: the current step is finished (or, for idle, a request arrives)
  always_comb begin
    unique case (ctrl.op)
      es2cd_pkg::OP_IDLE:  go = req.valid;
      es2cd_pkg::OP_ADJ:   go = 1'b1;
      es2cd_pkg::OP_DIV:   go = (ctrl.k == '0);
      es2cd_pkg::OP_MOV:   go = 1'b1;
      es2cd_pkg::OP_YEAR:  go = (days < {7'd0, ylen});
      es2cd_pkg::OP_MONTH: go = (month == es2cd_pkg::LAST_MONTH) || (days < {11'd0, mlen});
      es2cd_pkg::OP_DONE:  go = !rsp.valid || rsp.ready;
      default:             go = 1'b0;
    endcase
  end

  // datapath, driven by the current control word
  always_ff @(posedge clk) begin
    case (ctrl.op)
      es2cd_pkg::OP_IDLE: begin
        if (req.valid) begin
          epoch <= req.epoch_seconds;
        end
      end
      es2cd_pkg::OP_ADJ: begin
        rem <= adj_sat;
      end
      es2cd_pkg::OP_DIV: begin
        quo <= quo_calc;
      end
      es2cd_pkg::OP_MOV: begin
        case (ctrl.dsel)
          es2cd_pkg::SEL_HOUR: begin
            hour <= quo[4:0];
            rem  <= rem_low;
          end
          es2cd_pkg::SEL_MIN: begin
            // remainder after minutes is the second of the minute
            minute <= quo[5:0];
            second <= rem_low[5:0];
            year   <= es2cd_pkg::BASE_YEAR;
            month  <= '0;
          end
          default: begin
            days <= quo;
            rem  <= rem_low;
          end
        endcase
      end
      es2cd_pkg::OP_YEAR: begin
        if (!go) begin
          days <= days - {7'd0, ylen};
          year <= year + 12'd1;
        end
      end
      es2cd_pkg::OP_MONTH: begin
        if (!go) begin
          days  <= days - {11'd0, mlen};
          month <= month + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // response register, loaded at the final step
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((ctrl.op == es2cd_pkg::OP_DONE) && go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.op == es2cd_pkg::OP_DONE) && go) begin
      rsp.year         <= year;
      rsp.month        <= month + 4'd1;
      rsp.day_of_month <= days[4:0] + 5'd1;
      rsp.hour         <= hour;
      rsp.minute       <= minute;
      rsp.second       <= second;
    end
  end

endmodule
